// ===== src/bfe_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the edge-aware 3x3 box filter.
// No dependencies; used by every module of the filter.
package bfe_pkg;

  // Configuration port.
  localparam int CFG_DATA_BITS  = 11;
  localparam int CFG_INDEX_BITS = 1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  // Number of in-bounds neighbours that a sum is divided by.
  typedef enum logic [2:0] {
    DIV_BY_1,
    DIV_BY_2,
    DIV_BY_3,
    DIV_BY_4,
    DIV_BY_6,
    DIV_BY_9
  } div_code_t;

  // Per-item control carried from the position counters to the window stage.
  typedef struct packed {
    logic      emit;
    logic      last;
    logic      ok_r0;
    logic      ok_r2;
    logic      ok_c0;
    logic      ok_c2;
    logic      fwd;
    div_code_t div;
  } win_ctrl_t;

endpackage

// ===== src/box_filter_3x3_edge_aware.sv =====
`timescale 1ns / 1ps
// Top level of the edge-aware 3x3 box filter: position counters, pipeline control
// and output register. Depends on bfe_pkg, bfe_window and bfe_mean_div.
//
//   channel  direction  handshake            payload
//   in_      into       in_valid / in_stall  in_pixel_value, in_drain
//   out_     out of     out_valid/out_stall  out_smoothed_value, out_frame_last
//   cfg_     into       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item per cycle while no stalled result is held; the result of an item is registered
// through the line store read, then the window sum, then the divide into the output
// register. A stalled result freezes the whole pipeline and the input stalls with it.
// Reset clears counters, window and valid flags; the line store is not cleared.
// A configuration write restarts the frame and is taken in any cycle.
module box_filter_3x3_edge_aware #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [PIXEL_BITS-1:0]               in_pixel_value,
  input  logic                                in_drain,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [PIXEL_BITS-1:0]               out_smoothed_value,
  output logic                                out_frame_last,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bfe_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [bfe_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 2);
  localparam int OW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int SW = PIXEL_BITS + 4;
  localparam int W_RESET = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
  localparam int H_RESET = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;

  logic [WW-1:0] img_w_r;
  logic [HW-1:0] img_h_r;
  logic [CW-1:0] in_col_r;
  logic [RW-1:0] in_row_r;
  logic [CW-1:0] out_col_r;
  logic [OW-1:0] out_row_r;

  logic                  advance;
  logic                  flushing;
  logic                  ignored;
  logic                  live;
  logic [PIXEL_BITS-1:0] pix;
  logic [WW-1:0]         in_col_inc;
  logic [HW-1:0]         out_row_inc;
  logic [WW-1:0]         out_col_inc;
  logic [1:0]            n_rows;
  logic [1:0]            n_cols;
  bfe_pkg::win_ctrl_t    ctrl;
  logic [WW-1:0]         cfg_w;
  logic [HW-1:0]         cfg_h;

  logic                  s2_valid_r;
  bfe_pkg::win_ctrl_t    s2_ctrl_r;
  logic [CW-1:0]         s2_addr_r;
  logic [PIXEL_BITS-1:0] s2_pix_r;
  logic [SW-1:0]         s2_sum;

  logic                  s3_valid_r;
  logic [SW-1:0]         s3_sum_r;
  bfe_pkg::div_code_t    s3_div_r;
  logic                  s3_last_r;
  logic [PIXEL_BITS-1:0] s3_mean;

  logic                  out_valid_r;
  logic [PIXEL_BITS-1:0] out_value_r;
  logic                  out_last_r;

  assign advance   = !out_valid_r || !out_stall;
  assign in_stall  = !advance;
  assign cfg_ready = 1'b1;

  // Drain items arriving before the frame is complete leave no trace.
  assign flushing = in_row_r >= RW'(img_h_r);
  assign ignored  = in_drain && !flushing;
  assign live     = in_valid && advance && !ignored;
  assign pix      = flushing ? '0 : in_pixel_value;

  assign in_col_inc  = WW'(in_col_r) + WW'(1);
  assign out_row_inc = HW'(out_row_r) + HW'(1);
  assign out_col_inc = WW'(out_col_r) + WW'(1);

  always_comb begin
    ctrl.emit  = (in_row_r > RW'(1)) || ((in_row_r == RW'(1)) && (in_col_r != '0));
    ctrl.ok_r0 = out_row_r != '0;
    ctrl.ok_r2 = out_row_inc < img_h_r;
    ctrl.ok_c0 = out_col_r != '0;
    ctrl.ok_c2 = out_col_inc < img_w_r;
    ctrl.last  = !ctrl.ok_r2 && !ctrl.ok_c2;
    ctrl.fwd   = s2_valid_r && (s2_addr_r == in_col_r);
    n_rows     = 2'(ctrl.ok_r0) + 2'(ctrl.ok_r2);
    n_cols     = 2'(ctrl.ok_c0) + 2'(ctrl.ok_c2);
    unique case ({n_rows, n_cols})
      4'b0000: ctrl.div = bfe_pkg::DIV_BY_1;
      4'b0001: ctrl.div = bfe_pkg::DIV_BY_2;
      4'b0010: ctrl.div = bfe_pkg::DIV_BY_3;
      4'b0100: ctrl.div = bfe_pkg::DIV_BY_2;
      4'b0101: ctrl.div = bfe_pkg::DIV_BY_4;
      4'b0110: ctrl.div = bfe_pkg::DIV_BY_6;
      4'b1000: ctrl.div = bfe_pkg::DIV_BY_3;
      4'b1001: ctrl.div = bfe_pkg::DIV_BY_6;
      4'b1010: ctrl.div = bfe_pkg::DIV_BY_9;
      default: ctrl.div = bfe_pkg::DIV_BY_1;
    endcase
  end

  // A size of zero acts as one, and sizes above the maximum are clamped.
  always_comb begin
    if (cfg_data == '0) begin
      cfg_w = WW'(1);
    end else if (32'(cfg_data) > MAX_WIDTH) begin
      cfg_w = WW'(MAX_WIDTH);
    end else begin
      cfg_w = WW'(cfg_data);
    end
    if (cfg_data == '0) begin
      cfg_h = HW'(1);
    end else if (32'(cfg_data) > MAX_HEIGHT) begin
      cfg_h = HW'(MAX_HEIGHT);
    end else begin
      cfg_h = HW'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r   <= WW'(W_RESET);
      img_h_r   <= HW'(H_RESET);
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == bfe_pkg::CFG_IMAGE_WIDTH) begin
        img_w_r <= cfg_w;
      end
      if (cfg_index == bfe_pkg::CFG_IMAGE_HEIGHT) begin
        img_h_r <= cfg_h;
      end
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else if (live) begin
      if (ctrl.emit && ctrl.last) begin
        in_col_r  <= '0;
        in_row_r  <= '0;
        out_col_r <= '0;
        out_row_r <= '0;
      end else begin
        if (in_col_inc >= img_w_r) begin
          in_col_r <= '0;
          in_row_r <= in_row_r + RW'(1);
        end else begin
          in_col_r <= CW'(in_col_inc);
        end
        if (ctrl.emit) begin
          if (out_col_inc >= img_w_r) begin
            out_col_r <= '0;
            out_row_r <= OW'(out_row_inc);
          end else begin
            out_col_r <= CW'(out_col_inc);
          end
        end
      end
    end
  end

  // Window stage: line store read is issued at acceptance, and the registered read word is used when the item steps.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s2_valid_r  <= live;
      s3_valid_r  <= s2_valid_r && s2_ctrl_r.emit;
      out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_ctrl_r   <= ctrl;
      s2_addr_r   <= in_col_r;
      s2_pix_r    <= pix;
      s3_sum_r    <= s2_sum;
      s3_div_r    <= s2_ctrl_r.div;
      s3_last_r   <= s2_ctrl_r.last;
      out_value_r <= s3_mean;
      out_last_r  <= s3_last_r;
    end
  end

  bfe_window #(
    .PIXEL_BITS (PIXEL_BITS),
    .DEPTH      (MAX_WIDTH),
    .AW         (CW),
    .SW         (SW)
  ) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (live),
    .rd_addr (in_col_r),
    .step    (s2_valid_r && advance),
    .ctrl    (s2_ctrl_r),
    .wr_addr (s2_addr_r),
    .pix     (s2_pix_r),
    .sum     (s2_sum)
  );

  bfe_mean_div #(
    .PIXEL_BITS (PIXEL_BITS),
    .SW         (SW)
  ) u_mean_div (
    .sum  (s3_sum_r),
    .div  (s3_div_r),
    .mean (s3_mean)
  );

  assign out_valid          = out_valid_r;
  assign out_smoothed_value = out_value_r;
  assign out_frame_last     = out_last_r;

  // Consecutive items share a column only in a one-column image, or when the first item
  // of a frame follows the previous frame's last item, which always sits in column zero.
  a_fwd_shared_column: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && s2_ctrl_r.fwd |-> (img_w_r == WW'(1)) || (s2_addr_r == '0))
    else $error("line store forwarding outside a shared column");

  a_in_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    WW'(in_col_r) < img_w_r)
    else $error("input column counter beyond image width");

  a_out_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    WW'(out_col_r) < img_w_r)
    else $error("output column counter beyond image width");

  a_no_result_without_emit: assert property (@(posedge clk) disable iff (!rst_n)
    advance && s2_valid_r && !s2_ctrl_r.emit |=> !s3_valid_r)
    else $error("result produced for an item inside the startup lag");

endmodule

// ===== src/bfe_window.sv =====
`timescale 1ns / 1ps
// Line store memory, 3x3 window registers and neighbourhood adder.
// Depends on bfe_pkg.
module bfe_window #(
  parameter int PIXEL_BITS = 8,
  parameter int DEPTH      = 1024,
  parameter int AW         = 10,
  parameter int SW         = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  input  logic                step,
  input  bfe_pkg::win_ctrl_t  ctrl,
  input  logic [AW-1:0]       wr_addr,
  input  logic [PIXEL_BITS-1:0] pix,
  output logic [SW-1:0]       sum
);

  localparam int P = PIXEL_BITS;

  // Each entry holds the column's older row pixel (upper half) and newer row pixel.
  logic [2*P-1:0] mem [DEPTH];
  logic [2*P-1:0] rdata_r;
  logic [2*P-1:0] fwd_data_r;
  logic [2*P-1:0] rd_word;
  logic [2*P-1:0] wr_word;
  logic [P-1:0]   win_r   [3][3];
  logic [P-1:0]   win_nxt [3][3];
  logic [2:0]     row_ok;
  logic [2:0]     col_ok;

  // When consecutive items share a column (a one-pixel-wide image, or the first item
  // of a frame right behind the last item of the previous one) the next item reads the
  // entry written in the same cycle, so the written word is kept and used instead.
  assign rd_word = ctrl.fwd ? fwd_data_r : rdata_r;
  assign wr_word = {rd_word[P-1:0], pix};

  always_ff @(posedge clk) begin
    if (step) begin
      mem[wr_addr] <= wr_word;
      fwd_data_r   <= wr_word;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[r][0] = win_r[r][1];
      win_nxt[r][1] = win_r[r][2];
    end
    win_nxt[0][2] = rd_word[2*P-1:P];
    win_nxt[1][2] = rd_word[P-1:0];
    win_nxt[2][2] = pix;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else if (step) begin
      win_r <= win_nxt;
    end
  end

  assign row_ok = {ctrl.ok_r2, 1'b1, ctrl.ok_r0};
  assign col_ok = {ctrl.ok_c2, 1'b1, ctrl.ok_c0};

  always_comb begin
    sum = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (row_ok[r] && col_ok[c]) begin
          sum = sum + SW'(win_nxt[r][c]);
        end
      end
    end
  end

endmodule

// ===== src/bfe_mean_div.sv =====
`timescale 1ns / 1ps
// Division of a neighbourhood sum by 1, 2, 3, 4, 6 or 9 through a reciprocal multiply.
// Depends on bfe_pkg.
module bfe_mean_div #(
  parameter int PIXEL_BITS = 8,
  parameter int SW         = 12
) (
  input  logic [SW-1:0]         sum,
  input  bfe_pkg::div_code_t    div,
  output logic [PIXEL_BITS-1:0] mean
);

  // Four spare bits keep sum * rounding error below one step of the shift.
  localparam int K  = SW + 4;
  localparam int MW = K + 1;
  localparam logic [63:0] ONE_K = 64'd1 << K;
  localparam logic [MW-1:0] RECIP_1 = MW'(ONE_K);
  localparam logic [MW-1:0] RECIP_2 = MW'((ONE_K + 64'd1) / 2);
  localparam logic [MW-1:0] RECIP_3 = MW'((ONE_K + 64'd2) / 3);
  localparam logic [MW-1:0] RECIP_4 = MW'((ONE_K + 64'd3) / 4);
  localparam logic [MW-1:0] RECIP_6 = MW'((ONE_K + 64'd5) / 6);
  localparam logic [MW-1:0] RECIP_9 = MW'((ONE_K + 64'd8) / 9);

  logic [MW-1:0]    recip;
  logic [SW+MW-1:0] product;

  always_comb begin
    unique case (div)
      bfe_pkg::DIV_BY_1: recip = RECIP_1;
      bfe_pkg::DIV_BY_2: recip = RECIP_2;
      bfe_pkg::DIV_BY_3: recip = RECIP_3;
      bfe_pkg::DIV_BY_4: recip = RECIP_4;
      bfe_pkg::DIV_BY_6: recip = RECIP_6;
      bfe_pkg::DIV_BY_9: recip = RECIP_9;
      default:           recip = RECIP_1;
    endcase
  end

  assign product = (SW+MW)'(sum) * (SW+MW)'(recip);
  assign mean    = product[K +: PIXEL_BITS];

endmodule
